// ===== rtl/sspp_pkg.sv =====
// ----------------------------------------------------------------------------
// sspp_pkg
// Shared constants and types for the spherical shell point projection block.
// ----------------------------------------------------------------------------
package sspp_pkg;

  localparam int SSPP_COORD_WIDTH = 24;
  localparam int SSPP_FRAC_BITS   = 12;

  // The normal is always Q1.12, whatever the coordinate format.
  localparam int NORM_W    = 14;
  localparam int NORM_FRAC = 12;
  localparam int NORM_ONE  = 4096;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INNER = 2'd0,
    CFG_OUTER = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic in_shell;
    logic fully_inside;
    logic nearer_inner;
    logic at_origin;
  } sspp_flags_t;

  localparam int FLAGS_W = $bits(sspp_flags_t);

endpackage

// ===== rtl/sspp_sqrt.sv =====
// ----------------------------------------------------------------------------
// sspp_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module sspp_sqrt #(
  parameter int RW = 24,
  parameter int SW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  localparam int NW = 2 * RW;

  logic          v_q   [RW];
  logic [NW-1:0] n_q   [RW];
  logic [NW-1:0] res_q [RW];
  logic [SW-1:0] sb_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam logic [NW-1:0] Bit = {{(NW-1){1'b0}}, 1'b1} << (2 * (RW - 1 - k));
    logic          v_in;
    logic [NW-1:0] n_in;
    logic [NW-1:0] res_in;
    logic [SW-1:0] sb_in;
    logic [NW-1:0] trial;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign n_in   = rad_i;
      assign res_in = '0;
      assign sb_in  = side_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign n_in   = n_q[k-1];
      assign res_in = res_q[k-1];
      assign sb_in  = sb_q[k-1];
    end

    assign trial = res_in + Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (n_in >= trial) begin
        n_q[k]   <= n_in - trial;
        res_q[k] <= (res_in >> 1) + Bit;
      end else begin
        n_q[k]   <= n_in;
        res_q[k] <= res_in >> 1;
      end
      sb_q[k] <= sb_in;
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = res_q[RW-1][RW-1:0];
  assign side_o  = sb_q[RW-1];

endmodule

// ===== rtl/sspp_div.sv =====
// ----------------------------------------------------------------------------
// sspp_div
// Pipelined restoring divider, several lanes sharing one divisor. A front
// stage flags quotients that do not fit, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module sspp_div #(
  parameter int NW    = 47,
  parameter int DW    = 24,
  parameter int QW    = 24,
  parameter int LANES = 6,
  parameter int SW    = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NW-1:0]    num_i  [LANES],
  input  logic [DW-1:0]    den_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output logic [QW-1:0]    quot_o [LANES],
  output logic             ovf_o  [LANES],
  output logic [SW-1:0]    side_o
);

  localparam int EW = (NW > DW + QW) ? NW : DW + QW;

  // Front stage.
  logic          v0_q;
  logic [EW-1:0] rem0_q [LANES];
  logic          ovf0_q [LANES];
  logic [DW-1:0] d0_q;
  logic [SW-1:0] sb0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      rem0_q[l] <= EW'(num_i[l]);
      ovf0_q[l] <= EW'(num_i[l]) >= (EW'(den_i) << QW);
    end
    d0_q  <= den_i;
    sb0_q <= side_i;
  end

  logic          v_q   [QW];
  logic [EW-1:0] rem_q [QW][LANES];
  logic [QW-1:0] q_q   [QW][LANES];
  logic          ovf_q [QW][LANES];
  logic [DW-1:0] d_q   [QW];
  logic [SW-1:0] sb_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          v_in;
    logic [EW-1:0] rem_in [LANES];
    logic [QW-1:0] q_in   [LANES];
    logic          ovf_in [LANES];
    logic [DW-1:0] d_in;
    logic [SW-1:0] sb_in;
    logic [EW-1:0] dsh;

    if (k == 0) begin : g_first
      assign v_in   = v0_q;
      assign rem_in = rem0_q;
      assign ovf_in = ovf0_q;
      assign d_in   = d0_q;
      assign sb_in  = sb0_q;
      for (genvar l = 0; l < LANES; l++) begin : g_q0
        assign q_in[l] = '0;
      end
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign q_in   = q_q[k-1];
      assign ovf_in = ovf_q[k-1];
      assign d_in   = d_q[k-1];
      assign sb_in  = sb_q[k-1];
    end

    assign dsh = EW'(d_in) << (QW - 1 - k);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      for (int l = 0; l < LANES; l++) begin
        if (rem_in[l] >= dsh) begin
          rem_q[k][l] <= rem_in[l] - dsh;
          q_q[k][l]   <= {q_in[l][QW-2:0], 1'b1};
        end else begin
          rem_q[k][l] <= rem_in[l];
          q_q[k][l]   <= {q_in[l][QW-2:0], 1'b0};
        end
        ovf_q[k][l] <= ovf_in[l];
      end
      d_q[k]  <= d_in;
      sb_q[k] <= sb_in;
    end
  end

  assign valid_o = v_q[QW-1];
  assign quot_o  = q_q[QW-1];
  assign ovf_o   = ovf_q[QW-1];
  assign side_o  = sb_q[QW-1];

endmodule

// ===== rtl/spherical_shell_point_project.sv =====
// ----------------------------------------------------------------------------
// spherical_shell_point_project
// Tests a point against a spherical shell and projects it onto a surface.
// ----------------------------------------------------------------------------
// Usage: write the inner and outer radii through the cfg channel (index 0 is
// the inner radius, index 1 the outer) while no point is in flight. A point
// and an object radius are taken on each clock edge where start_i is high and
// busy_o is low. Each accepted point gives one done_o beat, high for one
// cycle, with the projection, the unit normal and the four flags. A new
// point can be started on every cycle, so the block sustains one point per
// clock; the pipeline runs through the square root (one root bit per stage)
// and the divider (one quotient bit per stage). There is no back-pressure on
// the result side: each done_o beat must be taken when it appears. Reset
// empties the pipeline, sets the inner radius to zero and the outer radius
// to one, and busy_o stays high until the first clock after reset is
// released.
// ----------------------------------------------------------------------------
module spherical_shell_point_project
  import sspp_pkg::*;
#(
  parameter int COORD_WIDTH = SSPP_COORD_WIDTH,
  parameter int FRAC_BITS   = SSPP_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  input  logic        [COORD_WIDTH-2:0] object_radius_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic        [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic        [COORD_WIDTH-2:0] cfg_data_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] proj_x_o,
  output logic signed [COORD_WIDTH-1:0] proj_y_o,
  output logic signed [COORD_WIDTH-1:0] proj_z_o,
  output logic signed [NORM_W-1:0]      normal_x_o,
  output logic signed [NORM_W-1:0]      normal_y_o,
  output logic signed [NORM_W-1:0]      normal_z_o,
  output logic                          in_shell_o,
  output logic                          fully_inside_o,
  output logic                          nearer_inner_o,
  output logic                          at_origin_o
);

  localparam int CW      = COORD_WIDTH;
  localparam int SQW     = 2 * CW;
  localparam int NW      = 2 * CW - 1;
  localparam int SW1     = FLAGS_W + 3 + 3 * CW + CW - 1;
  localparam int SW2     = FLAGS_W + 3 + CW - 1;
  localparam int Latency = 8 + 2 * CW;
  localparam logic [CW-1:0] Half = {1'b1, {(CW-1){1'b0}}};

  logic ready_q;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
    end else begin
      ready_q <= 1'b1;
    end
  end

  assign busy_o      = ~ready_q;
  assign cfg_ready_o = ready_q;
  assign accept      = start_i & ~busy_o;

  // Configuration registers.
  logic [CW-2:0] ri_q, ro_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ri_q <= '0;
      ro_q <= (CW-1)'(1) << FRAC_BITS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_INNER: ri_q <= cfg_data_i;
        CFG_OUTER: ro_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: magnitudes, signs, radius sums and the outer radius less the object radius.
  logic [CW-1:0] px [3];
  logic          v1_q;
  logic [CW-1:0] ax1_q [3];
  logic          sg1_q [3];
  logic [CW-1:0] a1_q, s1_q;
  logic [CW-2:0] b1_q;
  logic          bok1_q;

  assign px[0] = pos_x_i;
  assign px[1] = pos_y_i;
  assign px[2] = pos_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      ax1_q[i] <= px[i][CW-1] ? (~px[i] + CW'(1)) : px[i];
      sg1_q[i] <= px[i][CW-1];
    end
    a1_q   <= CW'(ri_q) + CW'(object_radius_i);
    s1_q   <= CW'(ri_q) + CW'(ro_q);
    b1_q   <= ro_q - object_radius_i;
    bok1_q <= object_radius_i <= ro_q;
  end

  // Stage 2: squares.
  logic           v2_q;
  logic [SQW-1:0] sq2_q [3];
  logic [SQW-1:0] ri2_q, ro2_q, a2_q, b2_q, s2_q;
  logic [CW-1:0]  ax2_q [3];
  logic           sg2_q [3];
  logic           bok2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq2_q[i] <= SQW'(ax1_q[i]) * SQW'(ax1_q[i]);
      ax2_q[i] <= ax1_q[i];
      sg2_q[i] <= sg1_q[i];
    end
    ri2_q  <= SQW'(ri_q) * SQW'(ri_q);
    ro2_q  <= SQW'(ro_q) * SQW'(ro_q);
    a2_q   <= SQW'(a1_q) * SQW'(a1_q);
    b2_q   <= SQW'(b1_q) * SQW'(b1_q);
    s2_q   <= SQW'(s1_q) * SQW'(s1_q);
    bok2_q <= bok1_q;
  end

  // Stage 3: squared norm.
  logic           v3_q;
  logic [SQW-1:0] n3_q;
  logic [SQW-1:0] ri3_q, ro3_q, a3_q, b3_q, s3_q;
  logic [CW-1:0]  ax3_q [3];
  logic           sg3_q [3];
  logic           bok3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n3_q   <= sq2_q[0] + sq2_q[1] + sq2_q[2];
    ri3_q  <= ri2_q;
    ro3_q  <= ro2_q;
    a3_q   <= a2_q;
    b3_q   <= b2_q;
    s3_q   <= s2_q;
    ax3_q  <= ax2_q;
    sg3_q  <= sg2_q;
    bok3_q <= bok2_q;
  end

  // Stage 4: exact comparisons on squares and choice of target surface.
  logic           v4_q;
  logic [SQW-1:0] n4_q;
  sspp_flags_t    fl4_q;
  logic [CW-2:0]  tgt4_q;
  logic [CW-1:0]  ax4_q [3];
  logic           sg4_q [3];
  logic           near3;

  assign near3 = n3_q <= (s3_q >> 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n4_q               <= n3_q;
    fl4_q.in_shell     <= (n3_q >= ri3_q) && (n3_q <= ro3_q);
    fl4_q.fully_inside <= (n3_q >= a3_q) && bok3_q && (n3_q <= b3_q);
    fl4_q.nearer_inner <= near3;
    fl4_q.at_origin    <= n3_q == '0;
    // At the origin the target is the inner radius, or the outer radius if the inner one is zero.
    if (n3_q == '0) begin
      tgt4_q <= (ri_q != '0) ? ri_q : ro_q;
    end else if (n3_q < ri3_q) begin
      tgt4_q <= ri_q;
    end else if (n3_q > ro3_q) begin
      tgt4_q <= ro_q;
    end else begin
      tgt4_q <= near3 ? ri_q : ro_q;
    end
    ax4_q <= ax3_q;
    sg4_q <= sg3_q;
  end

  // Square root.
  logic          vr;
  logic [CW-1:0] root;
  logic [SW1-1:0] sbr;
  sspp_flags_t   flr;
  logic          sgr [3];
  logic [CW-1:0] axr [3];
  logic [CW-2:0] tgtr;

  sspp_sqrt #(
    .RW (CW),
    .SW (SW1)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .rad_i   (n4_q),
    .side_i  ({fl4_q, sg4_q[0], sg4_q[1], sg4_q[2], ax4_q[0], ax4_q[1], ax4_q[2], tgt4_q}),
    .valid_o (vr),
    .root_o  (root),
    .side_o  (sbr)
  );

  assign {flr, sgr[0], sgr[1], sgr[2], axr[0], axr[1], axr[2], tgtr} = sbr;

  // Stage 5: numerators before rounding.
  logic          v5_q;
  logic [NW-1:0] num5_q [6];
  logic [CW-1:0] r5_q;
  logic [SW2-1:0] sb5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= vr;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      num5_q[i]     <= NW'(axr[i]) * NW'(tgtr);
      num5_q[3 + i] <= NW'(axr[i]) << NORM_FRAC;
    end
    r5_q  <= root;
    sb5_q <= {flr, sgr[0], sgr[1], sgr[2], tgtr};
  end

  // Stage 6: add half the divisor for rounding half away from zero.
  logic          v6_q;
  logic [NW-1:0] num6_q [6];
  logic [CW-1:0] r6_q;
  logic [SW2-1:0] sb6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 6; l++) begin
      num6_q[l] <= num5_q[l] + NW'(r5_q >> 1);
    end
    r6_q  <= r5_q;
    sb6_q <= sb5_q;
  end

  // Division by the norm.
  logic           vd;
  logic [CW-1:0]  dq   [6];
  logic           dovf [6];
  logic [SW2-1:0] sbd;
  sspp_flags_t    fld;
  logic           sgd [3];
  logic [CW-2:0]  tgtd;

  sspp_div #(
    .NW    (NW),
    .DW    (CW),
    .QW    (CW),
    .LANES (6),
    .SW    (SW2)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v6_q),
    .num_i   (num6_q),
    .den_i   (r6_q),
    .side_i  (sb6_q),
    .valid_o (vd),
    .quot_o  (dq),
    .ovf_o   (dovf),
    .side_o  (sbd)
  );

  assign {fld, sgd[0], sgd[1], sgd[2], tgtd} = sbd;

  // Final stage: saturation, signs and the origin case.
  logic [CW-1:0]     pmag [3];
  logic [CW-1:0]     pval [3];
  logic [NORM_W-1:0] nmag [3];
  logic [NORM_W-1:0] nval [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pmag[i] = (dovf[i] || dq[i] > Half) ? Half : dq[i];
      if (sgd[i]) begin
        pval[i] = ~pmag[i] + CW'(1);
      end else begin
        pval[i] = (pmag[i] == Half) ? (Half - CW'(1)) : pmag[i];
      end
      nmag[i] = (dovf[3 + i] || dq[3 + i] > CW'(NORM_ONE)) ?
                NORM_W'(NORM_ONE) : dq[3 + i][NORM_W-1:0];
      nval[i] = (sgd[i] ^ fld.nearer_inner) ? (~nmag[i] + NORM_W'(1)) : nmag[i];
    end
  end

  logic              done_q;
  logic [CW-1:0]     proj_q [3];
  logic [NORM_W-1:0] nrm_q  [3];
  sspp_flags_t       fl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    fl_q <= fld;
    if (fld.at_origin) begin
      proj_q[0] <= CW'(tgtd);
      proj_q[1] <= '0;
      proj_q[2] <= '0;
      nrm_q[0]  <= ~NORM_W'(NORM_ONE) + NORM_W'(1);
      nrm_q[1]  <= '0;
      nrm_q[2]  <= '0;
    end else begin
      proj_q <= pval;
      nrm_q  <= nval;
    end
  end

  assign done_o         = done_q;
  assign proj_x_o       = proj_q[0];
  assign proj_y_o       = proj_q[1];
  assign proj_z_o       = proj_q[2];
  assign normal_x_o     = nrm_q[0];
  assign normal_y_o     = nrm_q[1];
  assign normal_z_o     = nrm_q[2];
  assign in_shell_o     = fl_q.in_shell;
  assign fully_inside_o = fl_q.fully_inside;
  assign nearer_inner_o = fl_q.nearer_inner;
  assign at_origin_o    = fl_q.at_origin;

`ifndef SYNTH
  a_done_from_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Latency))
    else $error("result beat without a matching start");

  a_start_gives_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency done_o)
    else $error("accepted point produced no result beat");

  a_fully_in_shell : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && fully_inside_o) |-> in_shell_o)
    else $error("object inside the shell while its center is not");

  a_origin_normal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && at_origin_o) |-> (nearer_inner_o && normal_x_o == -NORM_ONE))
    else $error("origin result has the wrong normal");
`endif

endmodule
